// ----- src/lpma_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the lattice prefix-minimum block.
package lpma_pkg;

	localparam int MAX_DIMS   = 3;
	localparam int MAX_EXTENT = 16;
	localparam int FRAC_BITS  = 16;

	localparam int TIME_W = 32;
	localparam int AREA_W = 50;
	localparam int DIMS_W = 2;
	localparam int EXT_W  = 5;
	localparam int CFG_W  = 5;

	// coordinate width and store geometry
	localparam int CW     = $clog2(MAX_EXTENT);
	localparam int ADDR_W = CW * MAX_DIMS;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// reciprocal division of (coord << FRAC_BITS) by (extent - 1)
	localparam int XW = CW + FRAC_BITS;
	localparam int SH = XW + CW;
	localparam int MW = SH + 1;
	localparam int SW = XW + $clog2(MAX_DIMS + 1);
	localparam int PW = TIME_W + MW;

	typedef logic [MAX_DIMS-1:0][CW-1:0] coord_t;

	typedef enum logic [1:0] {
		CFG_DIMS = 2'd0,
		CFG_EXT0 = 2'd1,
		CFG_EXT1 = 2'd2,
		CFG_EXT2 = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] exec_time;
		logic              is_feasible;
		logic              first_point;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] best_time;
		logic              best_feasible;
		logic [CW-1:0]     alloc_dim0;
		logic [CW-1:0]     alloc_dim1;
		logic [CW-1:0]     alloc_dim2;
		logic [AREA_W-1:0] area_value;
	} result_t;

	// one kept-best entry per grid point
	typedef struct packed {
		logic              feas;
		logic [TIME_W-1:0] best_time;
		coord_t            alloc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// walk position and per-dimension divisor (extent - 1, zero if unused)
	typedef struct packed {
		coord_t coord;
		coord_t top;
	} walk_t;

endpackage

// ----- src/lpma_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module lpma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/lpma_mul.sv -----
`timescale 1ns / 1ps
// Shared unsigned multiplier with registered product.
module lpma_mul #(
	parameter int AW = 32,
	parameter int BW = 25
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);
	always_ff @(posedge clk) begin
		if (en) begin
			p <= {{BW{1'b0}}, a} * {{AW{1'b0}}, b};
		end
	end
endmodule

// ----- src/lpma_walk.sv -----
`timescale 1ns / 1ps
// Configuration registers and grid walk counter.
module lpma_walk (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  lpma_pkg::cfg_idx_t      cfg_index,
	input  logic [lpma_pkg::CFG_W-1:0] cfg_data,
	input  logic                    restart,
	input  logic                    advance,
	output lpma_pkg::walk_t         walk
);
	import lpma_pkg::*;

	logic [DIMS_W-1:0]                dims_q;
	logic [MAX_DIMS-1:0][EXT_W-1:0]   ext_q;
	coord_t                           coord_q;
	coord_t                           coord_n;
	logic [DIMS_W-1:0]                dims_eff;
	logic [MAX_DIMS-1:0][EXT_W-1:0]   ext_eff;

	// clamp registers to their legal ranges; unused dimensions have extent 1
	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DIMS_W'(1);
		end else if (dims_q > DIMS_W'(MAX_DIMS)) begin
			dims_eff = DIMS_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
		walk.coord = coord_q;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (d >= int'(dims_eff)) begin
				ext_eff[d] = EXT_W'(1);
			end else if (ext_q[d] == '0) begin
				ext_eff[d] = EXT_W'(1);
			end else if (ext_q[d] > EXT_W'(MAX_EXTENT)) begin
				ext_eff[d] = EXT_W'(MAX_EXTENT);
			end else begin
				ext_eff[d] = ext_q[d];
			end
			walk.top[d] = CW'(ext_eff[d] - EXT_W'(1));
		end
	end

	// next point, dimension 0 fastest, wrap to origin after the last
	always_comb begin
		logic          carry;
		logic [CW:0]   inc;
		carry   = 1'b1;
		coord_n = coord_q;
		for (int d = 0; d < MAX_DIMS; d++) begin
			inc = {1'b0, coord_q[d]} + (CW+1)'(1);
			if (carry) begin
				if (EXT_W'(inc) < ext_eff[d]) begin
					coord_n[d] = inc[CW-1:0];
					carry      = 1'b0;
				end else begin
					coord_n[d] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_W'(1);
			ext_q   <= {MAX_DIMS{EXT_W'(1)}};
			coord_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_DIMS: dims_q   <= cfg_data[DIMS_W-1:0];
				CFG_EXT0: ext_q[0] <= cfg_data[EXT_W-1:0];
				CFG_EXT1: ext_q[1] <= cfg_data[EXT_W-1:0];
				CFG_EXT2: ext_q[2] <= cfg_data[EXT_W-1:0];
			endcase
			coord_q <= '0;
		end else if (restart) begin
			coord_q <= '0;
		end else if (advance) begin
			coord_q <= coord_n;
		end
	end
endmodule

// ----- src/lattice_prefix_min_allocation.sv -----
`timescale 1ns / 1ps
// Top level: prefix minimum with argmin over a resource-allocation grid.
//
// Grid points arrive one transfer at a time in linear order, dimension 0
// fastest; first_point restarts the walk at the origin, and the walk wraps
// to the origin after the last point. For every point the block returns the
// least feasible time over all points not greater in any coordinate, the
// allocation that reaches it, and an area figure: best time times the sum of
// coordinate / (extent - 1) with FRAC_BITS fraction bits (the time itself,
// shifted, at the origin). Each item passes a read state and a compare
// state for each dimension in turn, then an area state and an output
// state, and the next item is accepted only once its result has been
// registered: the kept-best store has one read port, so the lower
// neighbours are fetched one dimension at a time, and a single multiplier
// serves both the per-dimension reciprocal division and the final
// area product. A finished result waits in an output register, and the next
// item is accepted while it waits. Configuration writes restart the walk;
// write only when the block is idle. The store needs no clearing after
// reset, since every neighbour read is a point written earlier in the same
// walk.
module lattice_prefix_min_allocation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  lpma_pkg::cfg_idx_t         cfg_index,
	input  logic [lpma_pkg::CFG_W-1:0] cfg_data,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  lpma_pkg::item_t            item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output lpma_pkg::result_t          result
);
	import lpma_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_AREA,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [DIM_IW-1:0]   dim_q;
	coord_t              cur_q;
	coord_t              alloc_q;
	logic [TIME_W-1:0]   time_q;
	logic                feas_q;
	logic [SW-1:0]       sum_q;
	result_t             result_q;
	logic                result_valid_q;

	walk_t               walk;
	logic                accept;
	logic                advance;
	logic                out_free;
	logic                origin;

	coord_t              nb_addr;
	logic                rd_en;
	logic                wr_en;
	entry_t              wr_entry;
	logic [ENTRY_W-1:0]  rd_data;
	entry_t              rd_entry;
	logic                take;

	logic                mul_en;
	logic [TIME_W-1:0]   mul_a;
	logic [MW-1:0]       mul_b;
	logic [PW-1:0]       prod;
	logic [MW-1:0]       recip [MAX_EXTENT];
	logic [CW-1:0]       cur_c;
	logic [CW-1:0]       cur_top;

	// Reciprocal table: ceil(2^SH / t), exact for (coord << FRAC_BITS) < 2^XW
	assign recip[0] = '0;
	for (genvar t = 1; t < MAX_EXTENT; t++) begin : g_recip
		localparam longint T  = t;
		localparam longint RC = ((64'd1 << SH) + T - 1) / T;
		assign recip[t] = MW'(RC);
	end

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign out_free   = !result_valid_q || result_ready;
	assign advance    = (state_q == ST_OUT) && out_free;
	assign origin     = (cur_q == '0);
	assign cur_c      = cur_q[dim_q];
	assign cur_top    = walk.top[dim_q];

	lpma_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (accept && item.first_point),
		.advance   (advance),
		.walk      (walk)
	);

	// lower neighbour along the current dimension
	always_comb begin
		nb_addr        = cur_q;
		nb_addr[dim_q] = cur_c - CW'(1);
	end

	assign rd_en = (state_q == ST_READ);
	assign wr_en = (state_q == ST_AREA);

	always_comb begin
		wr_entry.feas      = feas_q;
		wr_entry.best_time = feas_q ? time_q : '0;
		wr_entry.alloc     = alloc_q;
	end

	lpma_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cur_q),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (nb_addr),
		.rdata (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	// neighbour wins only when strictly better
	assign take = (cur_c != '0) && rd_entry.feas &&
		(!feas_q || (rd_entry.best_time < time_q));

	// shared multiplier: quotient per dimension, then the area product
	always_comb begin
		if (state_q == ST_AREA) begin
			mul_a = time_q;
			mul_b = {{(MW-SW){1'b0}}, sum_q};
		end else begin
			mul_a = {{(TIME_W-XW){1'b0}}, cur_c, {FRAC_BITS{1'b0}}};
			mul_b = recip[cur_top];
		end
	end

	assign mul_en = (state_q == ST_READ) || (state_q == ST_AREA);

	lpma_mul #(
		.AW (TIME_W),
		.BW (MW)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			dim_q          <= '0;
			cur_q          <= '0;
			alloc_q        <= '0;
			time_q         <= '0;
			feas_q         <= 1'b0;
			sum_q          <= '0;
			result_q       <= '0;
		end else begin
			// raise valid as a result is loaded, drop it once transferred
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// hold the point's own value as the first candidate
						cur_q   <= item.first_point ? '0 : walk.coord;
						alloc_q <= item.first_point ? '0 : walk.coord;
						time_q  <= item.exec_time;
						feas_q  <= item.is_feasible;
						dim_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (take) begin
						time_q  <= rd_entry.best_time;
						feas_q  <= 1'b1;
						alloc_q <= rd_entry.alloc;
					end
					sum_q <= sum_q + SW'(prod[SH +: XW]);
					if (dim_q == DIM_IW'(MAX_DIMS - 1)) begin
						state_q <= ST_AREA;
					end else begin
						dim_q   <= dim_q + DIM_IW'(1);
						state_q <= ST_READ;
					end
				end
				ST_AREA: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						result_q.best_time     <= feas_q ? time_q : '0;
						result_q.best_feasible <= feas_q;
						result_q.alloc_dim0    <= alloc_q[0];
						result_q.alloc_dim1    <= alloc_q[1];
						result_q.alloc_dim2    <= alloc_q[2];
						if (!feas_q) begin
							result_q.area_value <= '0;
						end else if (origin) begin
							result_q.area_value <=
								AREA_W'({time_q, {FRAC_BITS{1'b0}}});
						end else begin
							result_q.area_value <= prod[AREA_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the lattice prefix-minimum block: walks, checks and a running model.
module tb;
	import lpma_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_POINTS = 1050;
	localparam int MAX_WALK     = 300;

	// one grid point waiting to be offered, with the idle cycles drawn for it
	typedef struct {
		item_t       pt;
		int unsigned gap;
	} point_slot_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wen = 1'b0;
	cfg_idx_t  cfg_index = CFG_DIMS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	item_t     item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	result_t   result;

	lattice_prefix_min_allocation uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Running model of the block: kept-best store, walk position and a
	// copy of the registers as last written.
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] kept_time  [DEPTH];
	logic              kept_feas  [DEPTH];
	coord_t            kept_alloc [DEPTH];
	coord_t            walk_at = '0;
	logic [1:0]        model_dims = 2'd1;
	logic [4:0]        model_ext [3] = '{5'd1, 5'd1, 5'd1};

	// queues between the stimulus, the driver and the checker
	point_slot_t point_queue [$];
	result_t     best_queue [$];

	// bookkeeping
	int unsigned points_issued = 0;
	int unsigned points_taken = 0;
	int unsigned results_seen = 0;
	int unsigned feasible_seen = 0;
	int unsigned random_points = 0;
	int unsigned settings_used = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned walk_len = 1;
	int unsigned walk_pos = 0;
	logic        quiet_tx = 1'b0;
	logic        quiet_rx = 1'b0;
	logic        offering = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	logic        hold_go = 1'b0;
	int unsigned hold_left = 0;

	// Levels seen by the walk in dimension d: unused dimensions and a zero
	// extent count as one level, anything above the maximum is clipped.
	function automatic int unsigned clamp_extent(logic [1:0] dims, logic [4:0] raw, int d);
		int unsigned n;
		n = (dims == 2'd0) ? 1 : 32'(dims);
		if (d >= int'(n) || raw == 5'd0)
			return 1;
		if (raw > MAX_EXTENT)
			return MAX_EXTENT;
		return 32'(raw);
	endfunction

	function automatic int unsigned grid_size(logic [1:0] dims, logic [4:0] e0,
			logic [4:0] e1, logic [4:0] e2);
		return clamp_extent(dims, e0, 0) * clamp_extent(dims, e1, 1) *
			clamp_extent(dims, e2, 2);
	endfunction

	function automatic int unsigned eff_extent(int d);
		return clamp_extent(model_dims, model_ext[d], d);
	endfunction

	// Work out the result of one accepted point and fold it into the store.
	function automatic result_t prefix_min_point(item_t pt);
		coord_t            cur, nb, best_alloc;
		logic [TIME_W-1:0] t;
		logic              f, carry;
		logic [63:0]       sum, area;
		int unsigned       a, top;
		int                d;
		result_t           r;

		if (pt.first_point)
			walk_at = '0;
		cur = walk_at;
		t = pt.exec_time;
		f = pt.is_feasible;
		best_alloc = cur;

		// lower neighours in dimension order; a neighbour takes over only
		// when strictly better, so ties stay with the point itself
		for (d = 0; d < MAX_DIMS; d++) begin
			if (cur[d] != '0) begin
				nb = cur;
				nb[d] = nb[d] - CW'(1);
				a = 32'(nb);
				if (kept_feas[a] && (!f || kept_time[a] < t)) begin
					t = kept_time[a];
					f = 1'b1;
					best_alloc = kept_alloc[a];
				end
			end
		end

		a = 32'(cur);
		kept_time[a] = f ? t : '0;
		kept_feas[a] = f;
		kept_alloc[a] = best_alloc;

		area = '0;
		if (!f) begin
			t = '0;
		end else if (cur == '0) begin
			area = 64'(t) << FRAC_BITS;
		end else begin
			sum = '0;
			for (d = 0; d < MAX_DIMS; d++) begin
				top = eff_extent(d) - 1;
				if (top != 0)
					sum += (64'(cur[d]) << FRAC_BITS) / 64'(top);
			end
			area = 64'(t) * sum;
		end

		r.best_time = t;
		r.best_feasible = f;
		r.alloc_dim0 = best_alloc[0];
		r.alloc_dim1 = best_alloc[1];
		r.alloc_dim2 = best_alloc[2];
		r.area_value = area[AREA_W-1:0];

		// advance, dimension 0 fastest, wrapping to the origin after the last point
		carry = 1'b1;
		for (d = 0; d < MAX_DIMS; d++) begin
			if (carry) begin
				if (int'(cur[d]) + 1 < eff_extent(d)) begin
					walk_at[d] = cur[d] + CW'(1);
					carry = 1'b0;
				end else begin
					walk_at[d] = '0;
				end
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t: result %0d, %s: got %0h, expected %0h", $time, results_seen,
				what, got, want);
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic take_result(result_t got);
		result_t want;
		results_seen++;
		if (got.best_feasible)
			feasible_seen++;
		if (best_queue.size() == 0) begin
			report_mismatch("result with nothing outstanding", 64'(got.best_time), 64'(0));
			return;
		end
		want = best_queue.pop_front();
		check_field("best_time", 64'(got.best_time), 64'(want.best_time));
		check_field("best_feasible", 64'(got.best_feasible), 64'(want.best_feasible));
		check_field("alloc_dim0", 64'(got.alloc_dim0), 64'(want.alloc_dim0));
		check_field("alloc_dim1", 64'(got.alloc_dim1), 64'(want.alloc_dim1));
		check_field("alloc_dim2", 64'(got.alloc_dim2), 64'(want.alloc_dim2));
		check_field("area_value", 64'(got.area_value), 64'(want.area_value));
	endtask

	// ------------------------------------------------------------------
	// Driver: offer the head of the point queue once its idle cycles have
	// passed; hold valid and payload steady until the transfer.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			offering = 1'b0;
			tx_wait = 0;
		end else begin
			offering = item_valid;
			if (item_valid && item_ready) begin
				best_queue.push_back(prefix_min_point(item));
				points_taken++;
				offering = 1'b0;
			end
			if (!offering && point_queue.size() != 0) begin
				if (tx_wait < point_queue[0].gap) begin
					tx_wait++;
				end else begin
					item <= point_queue[0].pt;
					point_queue.delete(0);
					tx_wait = 0;
					offering = 1'b1;
				end
			end
			item_valid <= offering;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: after each transfer drop ready for a drawn number of
	// cycles; the long hold below overrides it. Quiet stretches keep ready
	// high throughout.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (result_valid && result_ready) begin
				take_result(result);
				if (results_seen % 32 == 0)
					quiet_rx = ($urandom_range(0, 2) == 0);
				rx_wait = quiet_rx ? 0 : $urandom_range(0, 15);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			result_ready <= (rx_wait == 0) && (hold_left == 0);
		end
	end

	// long receiver hold-off, counted here once the stimulus asks for it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				best_queue.size());
			$display("FAIL lattice_prefix_min_allocation");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_point(logic [TIME_W-1:0] t, logic feas, logic first);
		point_slot_t s;
		s.pt.exec_time = t;
		s.pt.is_feasible = feas;
		s.pt.first_point = first;
		s.gap = quiet_tx ? 0 : $urandom_range(0, 15);
		point_queue.push_back(s);
		points_issued++;
	endtask

	// hold until every issued point has come back as a result
	task automatic wait_idle();
		while (results_seen != points_issued)
			@(posedge clk);
	endtask

	// Write all four registers back to back; the block restarts its walk.
	task automatic write_setting(logic [4:0] dims_val, logic [4:0] e0, logic [4:0] e1,
			logic [4:0] e2);
		cfg_idx_t   r;
		logic [4:0] vals [4];
		int         i;
		vals = '{dims_val, e0, e1, e2};
		r = CFG_DIMS;
		for (i = 0; i < 4; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[i];
			@(posedge clk);
			r = r.next();
		end
		cfg_wen <= 1'b0;
		model_dims = dims_val[1:0];
		model_ext = '{e0, e1, e2};
		walk_at = '0;
		walk_len = grid_size(dims_val[1:0], e0, e1, e2);
		walk_pos = 0;
		settings_used++;
	endtask

	// small values breed ties, values near the top stress the area product
	function automatic logic [TIME_W-1:0] draw_time();
		case ($urandom_range(0, 3))
			0: begin
				return $urandom_range(0, 7);
			end
			1: begin
				return 32'hFFFF_FFFF - $urandom_range(0, 7);
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic logic [4:0] draw_extent();
		case ($urandom_range(0, 7))
			0: begin
				return 5'($urandom_range(0, 31));
			end
			1: begin
				return 5'(MAX_EXTENT);
			end
			default: begin
				return 5'($urandom_range(1, 5));
			end
		endcase
	endfunction

	// Queue well-formed walks with random content; now and then restart the
	// walk part way through to break the sequence.
	task automatic queue_walk(int unsigned n, int unsigned feas_pct, logic keep_quiet);
		int unsigned k;
		logic        restart;
		for (k = 0; k < n; k++) begin
			if (k % 32 == 0)
				quiet_tx = keep_quiet || ($urandom_range(0, 2) == 0);
			if (walk_pos == 0)
				restart = 1'($urandom_range(0, 1));
			else
				restart = ($urandom_range(0, 99) < 3);
			if (restart)
				walk_pos = 0;
			push_point(draw_time(), $urandom_range(0, 99) < feas_pct, restart);
			walk_pos = (walk_pos + 1) % walk_len;
			random_points++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		int unsigned ph, n, feas_pct, len;
		logic [4:0]  dv, e0, e1, e2;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: one dimension of one level, so every point is the
		// origin; extremes of the time and an infeasible origin.
		push_point(32'hFFFF_FFFF, 1'b1, 1'b0);
		push_point(32'h0000_0000, 1'b1, 1'b1);
		push_point(32'd5, 1'b0, 1'b0);
		wait_idle();

		// 2x2x2 cube: ties with the own value, neighbour takes over, an
		// infeasible point inheriting, equal neighbours in two dimensions
		write_setting(5'd3, 5'd2, 5'd2, 5'd2);
		push_point(32'd100, 1'b1, 1'b1);
		push_point(32'd100, 1'b1, 1'b0);
		push_point(32'd9, 1'b0, 1'b0);
		push_point(32'd100, 1'b1, 1'b0);
		push_point(32'd50, 1'b1, 1'b0);
		push_point(32'hFFFF_FFFF, 1'b1, 1'b0);
		push_point(32'd1, 1'b0, 1'b0);
		push_point(32'd200, 1'b1, 1'b0);
		// after the wrap: nothing feasible, and a restart part way through
		push_point(32'd7, 1'b0, 1'b1);
		push_point(32'd9, 1'b0, 1'b0);
		push_point(32'd3, 1'b0, 1'b1);
		push_point(32'd4, 1'b0, 1'b0);
		wait_idle();

		// out-of-range registers: dimension count masks to zero, extents
		// of 31 and 0 clip to the maximum and to one
		write_setting(5'b11100, 5'd31, 5'd0, 5'd16);
		push_point(32'hFFFF_FFFF, 1'b1, 1'b1);
		push_point(32'd0, 1'b0, 1'b0);
		push_point(32'd0, 1'b1, 1'b0);
		wait_idle();

		// Random phases, each under a fresh setting.
		ph = 0;
		while (random_points < RANDOM_POINTS) begin
			wait_idle();
			if (ph == 0) begin
				dv = 5'd3; e0 = 5'd16; e1 = 5'd4; e2 = 5'd4;
			end else if (ph == 3) begin
				dv = 5'd1; e0 = 5'd16; e1 = draw_extent(); e2 = draw_extent();
			end else begin
				do begin
					dv = 5'($urandom_range(0, 31));
					e0 = draw_extent();
					e1 = draw_extent();
					e2 = draw_extent();
					len = grid_size(dv[1:0], e0, e1, e2);
				end while (len > MAX_WALK);
			end
			write_setting(dv, e0, e1, e2);

			n = walk_len * $urandom_range(1, 2);
			if (n < 24)
				n = 24;
			if (n > 320)
				n = 320;
			if (n > RANDOM_POINTS - random_points)
				n = RANDOM_POINTS - random_points;
			case ($urandom_range(0, 2))
				0: feas_pct = 95;
				1: feas_pct = 60;
				default: feas_pct = 15;
			endcase

			if (ph == 1) begin
				// receiver holds off while the sender keeps offering back to back
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
				queue_walk(n, feas_pct, 1'b1);
			end else if (ph == 2) begin
				// sender pauses mid-walk until every result is home
				queue_walk(n / 2, feas_pct, 1'b0);
				wait_idle();
				queue_walk(n - n / 2, feas_pct, 1'b0);
			end else begin
				queue_walk(n, feas_pct, 1'b0);
			end
			ph++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (best_queue.size() != 0)
			report_mismatch("results never delivered", 64'(0), 64'(best_queue.size()));

		$display("covered %0d grid points under %0d register settings, %0d best results feasible",
			points_taken, settings_used, feasible_seen);
		$display("one receiver hold-off of %0d cycles and one mid-walk sender pause",
			LONG_HOLD);
		if (mismatches == 0) begin
			$display("PASS lattice_prefix_min_allocation");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL lattice_prefix_min_allocation");
		end
		$finish;
	end

endmodule
